/* rtl/core/sad_pkg.sv */
// Shared types and constants for the sinusoid amplitude / delay detector.
// No dependencies; sad_front, sad_back and the top level use it by scoped names.
package sad_pkg;

	// default sizing
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration register indexes
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	// reset values of the configuration registers
	localparam int PERIOD_RESET  = 64;
	localparam int CAPTURE_RESET = 4096;

	// depth of the queue between capture front end and analysis back end
	localparam int QUEUE_DEPTH = 4;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-sample flags decided by the front end
	typedef struct packed {
		logic first; // first sample of its phase bin in this capture
		logic last;  // last sample of the capture
	} sad_flags_t;

endpackage

/* rtl/core/sad_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sad_ram #(
	parameter int W = 16,
	parameter int D = 4096
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/core/sad_queue.sv */
// Small show-ahead queue between the capture front end and the back end.
// No dependencies.
module sad_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);
	localparam int PW = $clog2(DEPTH);

	logic [W-1:0] ent_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

/* rtl/core/sad_front.sv */
// Capture front end: takes sample requests, tracks sample index and phase bin,
// and tags each sample as first-of-bin / last-of-capture. Uses sad_pkg.
module sad_front #(
	parameter int MAX_SAMPLES = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic [$clog2(MAX_SAMPLES):0]      n_c,
	input  logic [$clog2(MAX_SAMPLES):0]      len_c,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [SAMPLE_BITS-1:0]            in_sample,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [SAMPLE_BITS+2*$clog2(MAX_SAMPLES)+1:0] q_data
);
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = AW + 1;

	logic [AW-1:0]       idx_q, bin_q;
	sad_pkg::sad_flags_t flags;

	assign in_ready    = !q_full;
	assign q_push      = in_valid && !q_full;
	assign flags.first = ({1'b0, idx_q} < n_c);
	assign flags.last  = (({1'b0, idx_q} + CW'(1)) == len_c);
	assign q_data      = {flags, bin_q, idx_q, in_sample};

	// sample index and phase bin counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			bin_q <= '0;
		end else if (restart) begin
			idx_q <= '0;
			bin_q <= '0;
		end else if (q_push) begin
			if (flags.last) begin
				idx_q <= '0;
				bin_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				bin_q <= (({1'b0, bin_q} + CW'(1)) == n_c) ? '0 : bin_q + 1'b1;
			end
		end
	end
endmodule

/* rtl/core/sad_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module sad_div #(
	parameter int NW = 29,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CNW = $clog2(NW + 1);

	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  rem_q, den_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic [DW:0]    trial;

	assign trial = {rem_q, quo_q[NW-1]};
	assign quo   = quo_q;

	// datapath: shift in one numerator bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DW'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

/* rtl/core/sad_back.sv */
// Back end: accumulates phase bins, then runs the peak / minimum analysis and
// holds the result register. Uses sad_pkg, sad_ram and sad_div.
module sad_back #(
	parameter int MAX_SAMPLES = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [$clog2(MAX_SAMPLES):0]                 n_c,
	input  logic [$clog2(MAX_SAMPLES):0]                 len_c,
	input  logic [SAMPLE_BITS+2*$clog2(MAX_SAMPLES)+1:0] q_head,
	input  logic                                         q_empty,
	output logic                                         q_pop,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic [SAMPLE_BITS-1:0]                       out_amp,
	output logic [$clog2(MAX_SAMPLES)-1:0]               out_delay,
	output sad_pkg::status_t                             out_status
);
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = AW + 1;
	localparam int JW = AW + 2;
	localparam int SW = SAMPLE_BITS + AW + 1;
	localparam int SB = SAMPLE_BITS;

	typedef enum logic [13:0] {
		S_ACC_RD  = 14'b00000000000001,
		S_ACC_WR  = 14'b00000000000010,
		S_SCAN_RD = 14'b00000000000100,
		S_SCAN_WT = 14'b00000000001000,
		S_LAST_RD = 14'b00000000010000,
		S_LAST_WT = 14'b00000000100000,
		S_PK_RD   = 14'b00000001000000,
		S_PK_WT   = 14'b00000010000000,
		S_MIN_RD  = 14'b00000100000000,
		S_MIN_WT  = 14'b00001000000000,
		S_DA_WT   = 14'b00010000000000,
		S_DB_WT   = 14'b00100000000000,
		S_EVAL    = 14'b01000000000000,
		S_DONE    = 14'b10000000000000
	} state_t;

	state_t state_q;

	// queue entry fields
	logic [SB-1:0]       h_x;
	logic [AW-1:0]       h_i, h_b;
	sad_pkg::sad_flags_t h_f;
	assign {h_f, h_b, h_i, h_x} = q_head;

	logic [SB-1:0]       x_q;
	logic [AW-1:0]       i_q, b_q;
	sad_pkg::sad_flags_t f_q;

	// memories
	logic          st_we, bn_we;
	logic [AW-1:0] st_raddr, bn_raddr;
	logic [SB-1:0] st_rdata;
	logic [CW+SW-1:0] bn_wdata, bn_rdata;
	logic [SW-1:0] bn_rsum;
	logic [CW-1:0] bn_rcnt;
	assign {bn_rcnt, bn_rsum} = bn_rdata;

	// analysis registers
	logic [AW-1:0] blast_q, k_q, best_q, peak_q;
	logic [SW-1:0] bsum_q, msum_q;
	logic [CW-1:0] bcnt_q, mcnt_q;
	logic [SB-1:0] lastv_q;
	logic [JW-1:0] j_q;
	logic [SW-1:0] qa_q;

	// result register
	logic [SB-1:0]     amp_q, r_amp_q;
	logic [AW-1:0]     r_delay_q;
	sad_pkg::status_t  r_st_q, st_q;
	logic              outv_q;

	// divider
	logic          dv_start, dv_done;
	logic [SW-1:0] dv_num, dv_quo;
	logic [CW-1:0] dv_den;

	// derived values
	logic [SW-1:0] x_ext, rd_ext;
	logic [CW:0]   diff;
	logic [CW-1:0] last_idx;
	logic [SB:0]   two_x, lastv_ext;
	logic [JW-1:0] j_next, len_j;
	logic [SW:0]   qsum;

	assign x_ext     = SW'(signed'(x_q));
	assign rd_ext    = SW'(signed'(st_rdata));
	assign diff      = (blast_q >= best_q) ? (CW+1)'(blast_q - best_q)
	                 : (CW+1)'({1'b0, blast_q} + n_c - {1'b0, best_q});
	assign last_idx  = CW'(len_c - CW'(1) - CW'(diff));
	assign two_x     = {st_rdata, 1'b0};
	assign lastv_ext = {lastv_q[SB-1], lastv_q};
	assign j_next    = j_q + JW'(n_c);
	assign len_j     = JW'(len_c);
	assign qsum      = {1'b0, qa_q} + {1'b0, dv_quo};

	assign q_pop = (state_q == S_ACC_RD) && !q_empty;

	// memory address and write selection
	always_comb begin
		bn_raddr = k_q;
		st_raddr = j_q[AW-1:0];
		if (state_q == S_ACC_RD) begin
			bn_raddr = h_b;
		end
		if (state_q == S_LAST_RD) begin
			st_raddr = last_idx[AW-1:0];
		end
		st_we = (state_q == S_ACC_WR);
		bn_we = (state_q == S_ACC_WR);
		if (f_q.first) begin
			bn_wdata = {CW'(1), x_ext};
		end else begin
			bn_wdata = {CW'(bn_rcnt + CW'(1)), SW'(bn_rsum + x_ext)};
		end
	end

	sad_ram #(.W(SB), .D(MAX_SAMPLES)) u_store (
		.clk(clk), .we(st_we), .waddr(i_q), .wdata(x_q),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	sad_ram #(.W(CW+SW), .D(MAX_SAMPLES)) u_bins (
		.clk(clk), .we(bn_we), .waddr(b_q), .wdata(bn_wdata),
		.raddr(bn_raddr), .rdata(bn_rdata)
	);

	// divider operands: magnitudes of the two sums
	always_comb begin
		dv_start = 1'b0;
		dv_num   = bsum_q[SW-1] ? SW'(-bsum_q) : bsum_q;
		dv_den   = bcnt_q;
		if (state_q == S_DA_WT && dv_done) begin
			dv_start = 1'b1;
			dv_num   = msum_q[SW-1] ? SW'(-msum_q) : msum_q;
			dv_den   = mcnt_q;
		end else if (state_q == S_EVAL) begin
			dv_start = (mcnt_q != '0) && (bcnt_q != '0);
		end
	end

	sad_div #(.NW(SW), .DW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den(dv_den), .done(dv_done), .quo(dv_quo)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_ACC_RD: begin
				x_q <= h_x;
				i_q <= h_i;
				b_q <= h_b;
				f_q <= h_f;
				k_q <= '0;
			end
			S_ACC_WR: begin
				blast_q <= b_q;
				amp_q   <= '0;
				peak_q  <= '0;
				st_q    <= sad_pkg::ST_SHORT;
			end
			S_SCAN_WT: begin
				if (k_q == '0 || $signed(bn_rsum) > $signed(bsum_q)) begin
					best_q <= k_q;
					bsum_q <= bn_rsum;
					bcnt_q <= bn_rcnt;
				end
				k_q <= k_q + 1'b1;
			end
			S_LAST_WT: begin
				lastv_q <= st_rdata;
				j_q     <= JW'(best_q);
				peak_q  <= best_q;
			end
			S_PK_WT: begin
				if ($signed(two_x) > $signed(lastv_ext)) begin
					peak_q <= j_q[AW-1:0];
					j_q    <= j_q + JW'(n_c >> 1);
				end else begin
					bsum_q <= bsum_q - rd_ext;
					bcnt_q <= bcnt_q - CW'(1);
					j_q    <= (j_next >= len_j) ? JW'(peak_q) + JW'(n_c >> 1) : j_next;
				end
				msum_q <= '0;
				mcnt_q <= '0;
			end
			S_MIN_WT: begin
				msum_q <= msum_q + rd_ext;
				mcnt_q <= mcnt_q + CW'(1);
				j_q    <= j_next;
			end
			S_EVAL: begin
				amp_q <= '0;
				st_q  <= sad_pkg::ST_EMPTY;
			end
			S_DA_WT: begin
				qa_q <= dv_quo;
			end
			S_DB_WT: begin
				amp_q <= qsum[SB:1];
				st_q  <= sad_pkg::ST_OK;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC_RD;
		end else begin
			case (state_q)
				S_ACC_RD: begin
					if (!q_empty) begin
						state_q <= S_ACC_WR;
					end
				end
				S_ACC_WR: begin
					if (!f_q.last) begin
						state_q <= S_ACC_RD;
					end else if (len_c < n_c) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_WT;
				S_SCAN_WT: begin
					state_q <= (({1'b0, k_q} + CW'(1)) == n_c) ? S_LAST_RD : S_SCAN_RD;
				end
				S_LAST_RD: state_q <= S_LAST_WT;
				S_LAST_WT: state_q <= S_PK_RD;
				S_PK_RD:   state_q <= S_PK_WT;
				S_PK_WT: begin
					if ($signed(two_x) > $signed(lastv_ext) || j_next >= len_j) begin
						state_q <= S_MIN_RD;
					end else begin
						state_q <= S_PK_RD;
					end
				end
				S_MIN_RD:  state_q <= (j_q >= len_j) ? S_EVAL : S_MIN_WT;
				S_MIN_WT:  state_q <= S_MIN_RD;
				S_EVAL: begin
					state_q <= (mcnt_q != '0 && bcnt_q != '0) ? S_DA_WT : S_DONE;
				end
				S_DA_WT: begin
					if (dv_done) begin
						state_q <= S_DB_WT;
					end
				end
				S_DB_WT: begin
					if (dv_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!outv_q) begin
						state_q <= S_ACC_RD;
					end
				end
				default: state_q <= S_ACC_RD;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && !outv_q) begin
			r_amp_q   <= amp_q;
			r_delay_q <= peak_q;
			r_st_q    <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
		end else if (state_q == S_DONE && !outv_q) begin
			outv_q <= 1'b1;
		end else if (out_ready) begin
			outv_q <= 1'b0;
		end
	end

	assign out_valid  = outv_q;
	assign out_amp    = r_amp_q;
	assign out_delay  = r_delay_q;
	assign out_status = r_st_q;
endmodule

/* rtl/core/sinusoid_amplitude_delay_detector.sv */
// Sinusoid amplitude / delay detector, top level.
// The back end handles each sample in a bin read state, then a bin write state;
// the input takes one request a cycle until the 4-entry queue fills.
// After the last sample: a bin scan (read, wait per bin), peak / minimum steps
// (read, wait each) and two divisions, then the result register; then capture resumes.
// Reset clears control state; stores are not cleared and need no sweep.
module sinusoid_amplitude_delay_detector #(
	parameter int MAX_SAMPLES = sad_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = sad_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [$clog2(MAX_SAMPLES):0]           cfg_data,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// tdata: sample, zero padded to bytes
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// tdata: amplitude, delay, status, zero padded to bytes
	output logic [((SAMPLE_BITS+$clog2(MAX_SAMPLES)+2+7)/8)*8-1:0] m_axis_tdata
);
	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = AW + 1;
	localparam int EW = SAMPLE_BITS + 2*AW + 2;
	localparam int OW = ((SAMPLE_BITS + AW + 2 + 7) / 8) * 8;

	logic [CW-1:0] period_q, length_q, n_c, len_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= CW'(sad_pkg::PERIOD_RESET);
			length_q <= CW'(sad_pkg::CAPTURE_RESET);
		end else if (cfg_we) begin
			if (cfg_index == sad_pkg::REG_PERIOD) begin
				period_q <= cfg_data;
			end else begin
				length_q <= cfg_data;
			end
		end
	end

	// clamp period to at least 1 and length to 1..MAX_SAMPLES
	assign n_c   = (period_q == '0) ? CW'(1) : period_q;
	assign len_c = (length_q == '0) ? CW'(1)
	             : (length_q > CW'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : length_q;

	logic          q_push, q_pop, q_full, q_empty;
	logic [EW-1:0] q_in, q_head;

	sad_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .restart(cfg_we), .n_c(n_c), .len_c(len_c),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_sample(s_axis_tdata[SAMPLE_BITS-1:0]),
		.q_full(q_full), .q_push(q_push), .q_data(q_in)
	);

	sad_queue #(.W(EW), .DEPTH(sad_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in),
		.pop(q_pop), .head(q_head), .full(q_full), .empty(q_empty)
	);

	logic [SAMPLE_BITS-1:0] amp;
	logic [AW-1:0]          delay;
	sad_pkg::status_t       status;

	sad_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .n_c(n_c), .len_c(len_c),
		.q_head(q_head), .q_empty(q_empty), .q_pop(q_pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_amp(amp), .out_delay(delay), .out_status(status)
	);

	assign m_axis_tdata = OW'({status, delay, amp});
endmodule

/* sim/tb_sinusoid_amplitude_delay_detector.sv */
// Testbench for the sinusoid amplitude / delay detector.
// Drives sample captures over the stream input, predicts each capture result
// and checks it field by field. Depends on sad_pkg and the detector RTL.
`timescale 1ns / 100ps

class sad_scoreboard;
	// predictor state
	int store [4096];
	longint bin_sum [4096];
	int bin_cnt [4096];
	int idx;
	int period;
	int cap_len;
	// expected results: {amplitude, delay, status}
	bit [29:0] pending [$];
	int errors;

	function void clear();
		idx = 0;
		period = sad_pkg::PERIOD_RESET;
		cap_len = sad_pkg::CAPTURE_RESET;
		errors = 0;
	endfunction

	function void write_reg(logic index, int value);
		if (index == sad_pkg::REG_PERIOD)
			period = value & 13'h1fff;
		else
			cap_len = value & 13'h1fff;
		idx = 0;
	endfunction

	function longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// analysis at the end of a capture
	function void analyze(int n, int len);
		int best, last, peak, j, mincnt;
		longint minsum, maxavg, minavg, amp;
		best = 0;
		minsum = 0;
		mincnt = 0;
		if (len < n) begin
			pending.push_back({16'd0, 12'd0, sad_pkg::ST_SHORT});
			return;
		end
		for (int b = 1; b < n; b++)
			if (bin_sum[b] > bin_sum[best])
				best = b;
		last = best + ((len - 1 - best) / n) * n;
		peak = best;
		for (j = best; j < len; j += n) begin
			if (2 * longint'(store[j]) > longint'(store[last])) begin
				peak = j;
				break;
			end
			bin_sum[best] -= store[j];
			bin_cnt[best]--;
		end
		for (j = peak + n / 2; j < len; j += n) begin
			minsum += store[j];
			mincnt++;
		end
		if (mincnt == 0 || bin_cnt[best] == 0) begin
			pending.push_back({16'd0, 12'(peak), sad_pkg::ST_EMPTY});
			return;
		end
		maxavg = bin_sum[best] / bin_cnt[best];
		minavg = minsum / mincnt;
		amp = (mag(maxavg) + mag(minavg)) / 2;
		pending.push_back({16'(amp), 12'(peak), sad_pkg::ST_OK});
	endfunction

	// note one accepted sample request
	function void note_sample(logic signed [15:0] x);
		int n, len, i, b;
		n = period == 0 ? 1 : period;
		len = cap_len < 1 ? 1 : (cap_len > 4096 ? 4096 : cap_len);
		i = idx >= len ? 0 : idx;
		store[i] = x;
		b = i % n;
		if (i < n) begin
			bin_sum[b] = x;
			bin_cnt[b] = 1;
		end else begin
			bin_sum[b] += x;
			bin_cnt[b]++;
		end
		idx = i + 1;
		if (idx < len)
			return;
		idx = 0;
		analyze(n, len);
	endfunction

	// compare one accepted result against the oldest expectation
	function void check_result(logic [31:0] data);
		bit [29:0] e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", data);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (data[15:0] !== e[29:14]) begin
			$error("amplitude: expected %0d, got %0d", e[29:14], data[15:0]);
			errors++;
		end
		if (data[27:16] !== e[13:2]) begin
			$error("delay: expected %0d, got %0d", e[13:2], data[27:16]);
			errors++;
		end
		if (data[29:28] !== e[1:0]) begin
			$error("status: expected %0d, got %0d", e[1:0], data[29:28]);
			errors++;
		end
		if (data[31:30] !== 2'b00) begin
			$error("padding: expected 0, got %0d", data[31:30]);
			errors++;
		end
	endfunction
endclass

module tb_sinusoid_amplitude_delay_detector;
	localparam int LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = sad_pkg::REG_PERIOD;
	logic [12:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	sad_scoreboard sb = new();
	int cycles = 0;
	bit out_busy = 1'b1;

	sinusoid_amplitude_delay_detector dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result receiver with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			m_axis_tready <= out_busy ? ($urandom_range(0, 9) < 6) : 1'b1;
		end
	end

	// valid stays high between back-to-back requests; a gap drops it
	task automatic send_sample(logic signed [15:0] x, bit allow_gap);
		int g;
		g = allow_gap ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= x;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(x);
	endtask

	// wait for outstanding results, then let analysis of a dropped capture settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20000) @(posedge clk);
	endtask

	// register write once every finished capture has delivered its result
	task automatic write_cfg(logic index, int value);
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[12:0];
		@(posedge clk);
		sb.write_reg(index, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one capture of a noisy tone with given period, phase and level
	task automatic tone_capture(int n, int len, int amp, int ph);
		int v;
		for (int i = 0; i < len; i++) begin
			v = ((i + ph) % n) * 2 < n ? amp : -amp;
			v += $signed($urandom_range(0, 2000)) - 1000;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			send_sample(16'(v), 1'b1);
		end
	endtask

	initial begin
		int n, len, sent;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sb.clear();

		// directed: short capture, extremes, empty average
		write_cfg(sad_pkg::REG_PERIOD, 4);
		write_cfg(sad_pkg::REG_LENGTH, 2);
		send_sample(16'sh7fff, 1'b0);
		send_sample(-16'sh8000, 1'b0);
		write_cfg(sad_pkg::REG_LENGTH, 8);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(-16'sh8000, 1'b1);
		send_sample(-16'sh0001, 1'b0);
		// early peak skipped (rising peak) then a tiny capture
		write_cfg(sad_pkg::REG_PERIOD, 2);
		write_cfg(sad_pkg::REG_LENGTH, 3);
		send_sample(16'sd10, 1'b0);
		send_sample(-16'sd5, 1'b0);
		send_sample(16'sd100, 1'b0);
		// register write mid-capture aborts
		write_cfg(sad_pkg::REG_LENGTH, 1);
		send_sample(16'sd1234, 1'b0);
		write_cfg(sad_pkg::REG_LENGTH, 6);
		send_sample(16'sd7, 1'b0);
		send_sample(16'sd7, 1'b0);
		write_cfg(sad_pkg::REG_PERIOD, 0);
		send_sample(-16'sd3, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(-16'sh5556, 1'b0);
		drain();

		// random phase: tones and noise over several settings
		sent = 0;
		while (sent < 700) begin
			n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(2, 16);
			len = $urandom_range(0, 19) == 0 ? $urandom_range(0, 8) : $urandom_range(n, 5 * n + 3);
			if ($urandom_range(0, 3) == 0) begin
				write_cfg(sad_pkg::REG_PERIOD, n);
				write_cfg(sad_pkg::REG_LENGTH, len);
			end else begin
				write_cfg(sad_pkg::REG_LENGTH, len);
				write_cfg(sad_pkg::REG_PERIOD, n);
			end
			n = n == 0 ? 1 : n;
			len = len < 1 ? 1 : (len > 4096 ? 4096 : len);
			for (int c = 0; c < 3; c++) begin
				if ($urandom_range(0, 4) == 0) begin
					for (int i = 0; i < len; i++)
						send_sample(16'($urandom()), 1'b1);
				end else
					tone_capture(n, len, $urandom_range(0, 32767), $urandom_range(0, n - 1));
				sent += len;
			end
			if ($urandom_range(0, 3) == 0)
				send_sample(16'($urandom()), 1'b1);
			out_busy = $urandom_range(0, 2) != 0;
			drain();
		end

		// one long capture with a long period
		write_cfg(sad_pkg::REG_PERIOD, 300);
		write_cfg(sad_pkg::REG_LENGTH, 1000);
		tone_capture(300, 1000, 20000, 100);
		drain();
		// period beyond the store size
		write_cfg(sad_pkg::REG_PERIOD, 8191);
		write_cfg(sad_pkg::REG_LENGTH, 40);
		for (int i = 0; i < 40; i++)
			send_sample(16'($urandom()), 1'b0);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
